// File: src/itxsort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itxsort_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = 6;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 7;
    localparam int DEPTH    = 64;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } emit_t;

    function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b);
        key_less = (a < b);
    endfunction

endpackage

`default_nettype wire

// File: src/itxsort_store.sv
`timescale 1ns / 1ps
`default_nettype none

module itxsort_store (
    input  wire logic                 clk,
    input  wire itxsort_pkg::mem_req_t req,
    output itxsort_pkg::entry_t       rdata
);

    itxsort_pkg::entry_t mem [itxsort_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// File: src/itxsort_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module itxsort_ctrl (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [itxsort_pkg::KEY_W-1:0] key_value,
    input  wire logic                                 last_key,
    input  wire itxsort_pkg::entry_t                  rdata,
    output itxsort_pkg::mem_req_t                     req,
    output itxsort_pkg::emit_t                        emit,
    output logic                                      busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOADI,
        S_WAITI,
        S_SCAN,
        S_WB,
        S_OUT,
        S_DONE
    } state_t;

    state_t                            state_reg;
    logic [itxsort_pkg::CNT_W-1:0]     count_reg;
    logic                              ovf_reg;
    logic [itxsort_pkg::ADDR_W-1:0]    i_reg;
    logic [itxsort_pkg::CNT_W-1:0]     j_reg;
    logic [itxsort_pkg::ADDR_W-1:0]    jd_reg;
    logic [itxsort_pkg::ADDR_W-1:0]    k_reg;
    itxsort_pkg::entry_t               ri_reg;

    logic swap;
    logic i_last;
    logic k_last;
    logic has_room;

    assign busy     = (state_reg != S_IDLE);
    assign has_room = (count_reg < itxsort_pkg::CNT_W'(itxsort_pkg::MAX_KEYS));
    // row i holds the running key in ri_reg; memory slot i is stale until write-back
    assign swap     = (jd_reg != i_reg) && itxsort_pkg::key_less(ri_reg.key, rdata.key);
    assign i_last   = ({1'b0, i_reg} + itxsort_pkg::CNT_W'(1)) == count_reg;
    assign k_last   = ({1'b0, k_reg} + itxsort_pkg::CNT_W'(1)) == count_reg;

    always_comb
    begin
        req       = '0;
        emit      = '0;
        emit.ovf  = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && has_room)
                begin
                    req.we        = 1'b1;
                    req.waddr     = count_reg[itxsort_pkg::ADDR_W-1:0];
                    req.wdata.key = key_value;
                    req.wdata.idx = count_reg[itxsort_pkg::IDX_W-1:0];
                end
            end
            S_LOADI:
            begin
                req.raddr = i_reg;
            end
            S_WAITI:
            begin
                req.raddr = '0;
            end
            S_SCAN:
            begin
                if (swap)
                begin
                    req.we    = 1'b1;
                    req.waddr = jd_reg;
                    req.wdata = ri_reg;
                end
                req.raddr = j_reg[itxsort_pkg::ADDR_W-1:0];
            end
            S_WB:
            begin
                req.we    = 1'b1;
                req.waddr = i_reg;
                req.wdata = ri_reg;
                req.raddr = i_reg + itxsort_pkg::ADDR_W'(1);
            end
            S_OUT:
            begin
                req.raddr  = k_reg;
                emit.valid = 1'b1;
                emit.last  = k_last;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            jd_reg    <= '0;
            k_reg     <= '0;
            ri_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + itxsort_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_key)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_LOADI;
                        end
                    end
                end
                S_LOADI:
                begin
                    state_reg <= S_WAITI;
                end
                S_WAITI:
                begin
                    ri_reg    <= rdata;
                    jd_reg    <= '0;
                    j_reg     <= itxsort_pkg::CNT_W'(1);
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (swap)
                    begin
                        ri_reg <= rdata;
                    end
                    if (j_reg < count_reg)
                    begin
                        jd_reg <= j_reg[itxsort_pkg::ADDR_W-1:0];
                        j_reg  <= j_reg + itxsort_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (i_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + itxsort_pkg::ADDR_W'(1);
                        state_reg <= S_WAITI;
                    end
                end
                S_OUT:
                begin
                    if (k_last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg <= k_reg + itxsort_pkg::ADDR_W'(1);
                    end
                end
                S_DONE:
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/index_tracking_exchange_sort_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// request   in         start & !busy          key_value, last_key
// result    out        result_valid (1 clk)   sorted_key, original_index,
//                                              overflow_seen, last_result
//
// A key without last_key is stored while the core stays idle. The closing request starts the
// sort: one row per stored key on the single compare unit and the one-read, one-write
// key store, then the sorted keys are read out in order.
// busy stays high from the closing request until the final result has gone out.
// Results come out back to back, one per cycle; the receiver cannot stall them.
// Reset (rst_n, async) empties the set and clears the overflow flag.

module index_tracking_exchange_sort_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [itxsort_pkg::KEY_W-1:0] key_value,
    input  wire logic                                 last_key,
    output logic                                      result_valid,
    output logic signed [itxsort_pkg::KEY_W-1:0]      sorted_key,
    output logic [itxsort_pkg::IDX_W-1:0]             original_index,
    output logic                                      overflow_seen,
    output logic                                      last_result
);

    itxsort_pkg::mem_req_t req;
    itxsort_pkg::entry_t   rdata;
    itxsort_pkg::emit_t    emit;
    logic                  ctrl_busy;

    itxsort_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    itxsort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .key_value (key_value),
        .last_key  (last_key),
        .rdata     (rdata),
        .req       (req),
        .emit      (emit),
        .busy      (ctrl_busy)
    );

    // result strobe lines up with the registered store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid  <= 1'b0;
            last_result   <= 1'b0;
            overflow_seen <= 1'b0;
        end
        else
        begin
            result_valid  <= emit.valid;
            last_result   <= emit.last;
            overflow_seen <= emit.ovf;
        end
    end

    assign busy           = ctrl_busy;
    assign sorted_key     = rdata.key;
    assign original_index = rdata.idx;

    a_close_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_key) |=> busy)
        else $error("closing request did not start the sort");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a busy period");

    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |=> result_valid)
        else $error("gap inside result burst");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> (!result_valid && !busy))
        else $error("result after last of set");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT  = 20000;  // well above the quiet time of one full 64-key sort
    localparam int SETTLE_LIMIT = 64;
    localparam int IDLE_PCT     = 37;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 360;

    typedef struct packed {
        logic signed [itxsort_pkg::KEY_W-1:0] key;
        logic [itxsort_pkg::IDX_W-1:0]        idx;
        logic                                 ovf;
        logic                                 last;
    } sorted_entry_t;

    class sort_scoreboard;
        logic signed [itxsort_pkg::KEY_W-1:0] key_mem [itxsort_pkg::MAX_KEYS];
        logic [itxsort_pkg::IDX_W-1:0]        idx_mem [itxsort_pkg::MAX_KEYS];
        int unsigned                          key_count;
        bit                                   dropped;
        sorted_entry_t                        sorted_queue [$];
        int unsigned                          mismatch_count;

        function new();
            key_count      = 0;
            dropped        = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return sorted_queue.size();
        endfunction

        // Stores the key if there is room, else marks the set as dropped; a closing request
        // runs the full i/j exchange pass and queues one sorted entry per stored key.
        function void note_request(logic signed [itxsort_pkg::KEY_W-1:0] key, logic last);
            logic signed [itxsort_pkg::KEY_W-1:0] tk;
            logic [itxsort_pkg::IDX_W-1:0]        ti;
            sorted_entry_t                        e;
            if (key_count < itxsort_pkg::MAX_KEYS)
            begin
                key_mem[key_count] = key;
                idx_mem[key_count] = key_count[itxsort_pkg::IDX_W-1:0];
                key_count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!last)
                return;
            for (int i = 0; i < key_count; i++)
            begin
                for (int j = 0; j < key_count; j++)
                begin
                    if (key_mem[i] < key_mem[j])
                    begin
                        tk = key_mem[i];
                        ti = idx_mem[i];
                        key_mem[i] = key_mem[j];
                        idx_mem[i] = idx_mem[j];
                        key_mem[j] = tk;
                        idx_mem[j] = ti;
                    end
                end
            end
            for (int k = 0; k < key_count; k++)
            begin
                e.key  = key_mem[k];
                e.idx  = idx_mem[k];
                e.ovf  = dropped;
                e.last = (k + 1 == key_count);
                sorted_queue = {sorted_queue, e};
            end
            key_count = 0;
            dropped   = 1'b0;
        endfunction

        function void check_result(logic signed [itxsort_pkg::KEY_W-1:0] key,
                                   logic [itxsort_pkg::IDX_W-1:0] idx,
                                   logic ovf, logic last);
            sorted_entry_t got;
            sorted_entry_t want;
            got = '{key, idx, ovf, last};
            if (sorted_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result key=%0d idx=%0d ovf=%0b last=%0b",
                             $realtime, key, idx, ovf, last);
                return;
            end
            want = sorted_queue.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"%0t: mismatch exp key=%0d idx=%0d ovf=%0b last=%0b,",
                              " got key=%0d idx=%0d ovf=%0b last=%0b"},
                             $realtime, want.key, want.idx, want.ovf, want.last,
                             key, idx, ovf, last);
            end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [itxsort_pkg::KEY_W-1:0] key_value;
    logic                                 last_key;
    logic                                 result_valid;
    logic signed [itxsort_pkg::KEY_W-1:0] sorted_key;
    logic [itxsort_pkg::IDX_W-1:0]        original_index;
    logic                                 overflow_seen;
    logic                                 last_result;

    sort_scoreboard sb;
    bit             steady;
    int unsigned    sent_items;
    int unsigned    quiet_cycles;

    index_tracking_exchange_sort_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .key_value      (key_value),
        .last_key       (last_key),
        .result_valid   (result_valid),
        .sorted_key     (sorted_key),
        .original_index (original_index),
        .overflow_seen  (overflow_seen),
        .last_result    (last_result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(sorted_key, original_index, overflow_seen, last_result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [itxsort_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    default: return 32'sh0001_0000;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 7)) - 4;  // dense range, many ties
            default: return $urandom;
        endcase
    endfunction

    // Holds the request until the core takes it, with random gaps before it outside the steady sets.
    task automatic send_key(input logic signed [itxsort_pkg::KEY_W-1:0] key,
                            input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start     <= 1'b0;
            key_value <= $urandom;
            last_key  <= $urandom_range(0, 1);
            @(posedge clk);
        end
        start     <= 1'b1;
        key_value <= key;
        last_key  <= last;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(key, last);
        sent_items++;
    endtask

    task automatic send_set(input int unsigned n);
        for (int k = 0; k < n; k++)
            send_key(pick_key(), k == n - 1);
    endtask

    task automatic wait_sorted_out();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned set_no;
        int unsigned n;
        sb           = new();
        steady       = 1'b0;
        sent_items   = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        key_value    = '0;
        last_key     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, alternating bit patterns and ties in one set
        send_key(32'sh7FFF_FFFF, 1'b0);
        send_key(32'sh8000_0000, 1'b0);
        send_key(32'sh0000_0000, 1'b0);
        send_key(-32'sd1, 1'b0);
        send_key(32'shAAAA_5555, 1'b0);
        send_key(32'sh5555_AAAA, 1'b0);
        send_key(32'sh0001_0000, 1'b0);
        send_key(32'sh0001_0000, 1'b0);
        send_key(32'sh8000_0000, 1'b1);
        // single-key set
        send_key(32'sh1234_5678, 1'b1);
        // all keys equal
        repeat (4) send_key(32'sh0000_0003, 1'b0);
        send_key(32'sh0000_0003, 1'b1);
        // already descending, then already ascending
        send_key(32'sh0000_0010, 1'b0);
        send_key(-32'sd16, 1'b1);
        send_key(-32'sd16, 1'b0);
        send_key(32'sh0000_0010, 1'b1);

        set_no = 0;
        while (sent_items < RANDOM_ITEMS + 16)
        begin
            steady = (set_no >= 15 && set_no < 25);
            if (set_no == 3)
                n = itxsort_pkg::MAX_KEYS;
            else if (set_no == 7 || set_no == 12)
                n = itxsort_pkg::MAX_KEYS + $urandom_range(1, 3);  // extra requests are dropped
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(9, 20);
            else
                n = $urandom_range(1, 8);
            send_set(n);
            if (set_no == 10)
                wait_sorted_out();
            set_no++;
        end

        wait_sorted_out();
        repeat (SETTLE_LIMIT) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
